[hw/rtl/stsel_pkg.sv]
// ----------------------------------------------------------------------------
// stsel_pkg: shared types and constants of the sticky target selector
// Item, queue entry and result layouts, register indexes and mode codes.
// ----------------------------------------------------------------------------
package stsel_pkg;

  localparam int TIME_COUNTER_BITS_DEF = 16;
  localparam int QUEUE_AW_DEF          = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TIMEOUT_W  = 16;
  localparam int DIST_W     = 31;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_FILTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_ID       = 3'd4;

  // Follow modes.
  localparam logic [1:0] FOLLOW_BEST  = 2'd0;
  localparam logic [1:0] FOLLOW_ID    = 2'd1;

  // Selection policies; any other code ranks by confidence.
  localparam logic [1:0] POL_NEAREST  = 2'd1;
  localparam logic [1:0] POL_LARGEST  = 2'd2;

  typedef struct packed {
    logic               mode;
    logic               has_track;
    logic               last_of_frame;
    logic [31:0]        trk_id;
    logic [7:0]         obj_class;
    logic [15:0]        confidence;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [15:0]        size_ratio;
  } in_item_t;

  typedef struct packed {
    logic               target_found;
    logic               from_timer;
    logic [31:0]        target_track_id;
    logic [7:0]         target_class;
    logic [15:0]        target_confidence;
    logic signed [15:0] target_center_x;
    logic signed [15:0] target_center_y;
    logic [15:0]        target_size;
  } result_t;

  typedef struct packed {
    logic [31:0]        trk_id;
    logic [7:0]         obj_class;
    logic [15:0]        confidence;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [15:0]        size_ratio;
  } track_rec_t;

  // Classified item as it travels from the front to the back.
  typedef struct packed {
    logic                is_tick;
    logic                has_track;
    logic                last;
    track_rec_t          rec;
    logic [DIST_W-1:0]   sq_dist;
  } mid_item_t;

endpackage

[hw/rtl/stsel_fifo.sv]
// ----------------------------------------------------------------------------
// stsel_fifo: small synchronous queue
// Register-array queue with full and empty flags and a show-ahead read port.
// ----------------------------------------------------------------------------
module stsel_fifo #(
  parameter int WIDTH = 8,
  parameter int AW    = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int DEPTH = 2 ** AW;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= wdata;
    end
  end

endmodule

[hw/rtl/stsel_front.sv]
// ----------------------------------------------------------------------------
// stsel_front: input stage of the sticky target selector
// Captures items, squares the centre offsets and hands classified entries
// with their saturated distance to the queue.
// ----------------------------------------------------------------------------
module stsel_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  stsel_pkg::in_item_t  in_data,
  output logic                 in_full,
  output logic                 mid_push,
  output stsel_pkg::mid_item_t mid_data,
  input  logic                 mid_full
);

  stsel_pkg::in_item_t s1_item_r;
  logic                s1_vld_r, s1_vld_nxt;
  logic [30:0]         sq_x_r, sq_y_r;
  logic signed [31:0]  prod_x, prod_y;
  logic [31:0]         dist_sum;
  logic                accept;

  assign in_full  = s1_vld_r && mid_full;
  assign accept   = in_push && !in_full;
  assign mid_push = s1_vld_r && !mid_full;

  assign prod_x = in_data.center_x * in_data.center_x;
  assign prod_y = in_data.center_y * in_data.center_y;

  // Each square is at most 2^30, so the sum needs 32 bits before saturation.
  assign dist_sum = {1'b0, sq_x_r} + {1'b0, sq_y_r};

  always_comb begin
    s1_vld_nxt = accept || (s1_vld_r && mid_full);

    mid_data.is_tick           = s1_item_r.mode;
    mid_data.has_track         = s1_item_r.has_track;
    mid_data.last              = s1_item_r.last_of_frame;
    mid_data.rec.trk_id        = s1_item_r.trk_id;
    mid_data.rec.obj_class     = s1_item_r.obj_class;
    mid_data.rec.confidence    = s1_item_r.confidence;
    mid_data.rec.center_x      = s1_item_r.center_x;
    mid_data.rec.center_y      = s1_item_r.center_y;
    mid_data.rec.size_ratio    = s1_item_r.size_ratio;
    mid_data.sq_dist           = dist_sum[31] ? {stsel_pkg::DIST_W{1'b1}}
                                              : dist_sum[stsel_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
      sq_x_r    <= prod_x[30:0];
      sq_y_r    <= prod_y[30:0];
    end
  end

endmodule

[hw/rtl/stsel_back.sv]
// ----------------------------------------------------------------------------
// stsel_back: decision stage of the sticky target selector
// Holds configuration, lock, running match and best, and the tick counters; it retires
// one queued entry per cycle unless out_full or cfg_we stalls it, and produces at most one result.
// ----------------------------------------------------------------------------
module stsel_back #(
  parameter int TIME_COUNTER_BITS = stsel_pkg::TIME_COUNTER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [stsel_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stsel_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                mid_empty,
  input  stsel_pkg::mid_item_t                mid_data,
  output logic                                mid_pop,
  input  logic                                out_full,
  output logic                                res_push,
  output stsel_pkg::result_t                  res_data
);

  localparam int TCB = TIME_COUNTER_BITS;
  localparam int CW  = (TCB > stsel_pkg::TIMEOUT_W) ? TCB : stsel_pkg::TIMEOUT_W;

  logic [1:0]                        follow_mode_r, follow_mode_nxt;
  logic [7:0]                        class_filter_r, class_filter_nxt;
  logic [1:0]                        policy_r, policy_nxt;
  logic [stsel_pkg::TIMEOUT_W-1:0]   timeout_r, timeout_nxt;
  logic [31:0]                       req_id_r, req_id_nxt;
  logic [31:0]                       lock_r, lock_nxt;

  stsel_pkg::track_rec_t             held0_r, held0_nxt, held1_r, held1_nxt;
  logic                              hv0_r, hv0_nxt, hv1_r, hv1_nxt;
  logic [stsel_pkg::DIST_W-1:0]      best_dist_r, best_dist_nxt;
  logic [TCB-1:0]                    tst_r, tst_nxt, tsf_r, tsf_nxt;
  logic [TCB-1:0]                    tst_inc, tsf_inc;

  logic                              fire, res_vld, cand, match, better, cfg_hit;
  stsel_pkg::track_rec_t             rec;

  function automatic stsel_pkg::result_t found_result(stsel_pkg::track_rec_t r);
    stsel_pkg::result_t res;
    res.target_found      = 1'b1;
    res.from_timer        = 1'b0;
    res.target_track_id   = r.trk_id;
    res.target_class      = r.obj_class;
    res.target_confidence = r.confidence;
    res.target_center_x   = r.center_x;
    res.target_center_y   = r.center_y;
    res.target_size       = r.size_ratio;
    return res;
  endfunction

  // A register write takes the cycle, so no entry is retired alongside it.
  assign fire     = !mid_empty && !out_full && !cfg_we;
  assign mid_pop  = fire;
  assign res_push = fire && res_vld;
  assign rec      = mid_data.rec;

  assign tst_inc = (tst_r == {TCB{1'b1}}) ? tst_r : tst_r + 1'b1;
  assign tsf_inc = (tsf_r == {TCB{1'b1}}) ? tsf_r : tsf_r + 1'b1;

  assign cand  = mid_data.has_track && (rec.obj_class == class_filter_r) &&
                 (rec.trk_id != '0);
  assign match = mid_data.has_track &&
                 (((follow_mode_r == stsel_pkg::FOLLOW_BEST) && cand &&
                   (rec.trk_id == lock_r)) ||
                  ((follow_mode_r == stsel_pkg::FOLLOW_ID) && (rec.trk_id == lock_r)));

  always_comb begin
    if (!hv1_r) begin
      better = 1'b1;
    end else begin
      unique case (policy_r)
        stsel_pkg::POL_NEAREST: better = mid_data.sq_dist < best_dist_r;
        stsel_pkg::POL_LARGEST: better = rec.size_ratio > held1_r.size_ratio;
        default:                better = rec.confidence > held1_r.confidence;
      endcase
    end
  end

  always_comb begin
    follow_mode_nxt  = follow_mode_r;
    class_filter_nxt = class_filter_r;
    policy_nxt       = policy_r;
    timeout_nxt      = timeout_r;
    req_id_nxt       = req_id_r;
    lock_nxt         = lock_r;
    held0_nxt        = held0_r;
    held1_nxt        = held1_r;
    hv0_nxt          = hv0_r;
    hv1_nxt          = hv1_r;
    best_dist_nxt    = best_dist_r;
    tst_nxt          = tst_r;
    tsf_nxt          = tsf_r;
    res_vld          = 1'b0;
    res_data         = '0;
    cfg_hit          = 1'b1;

    if (cfg_we) begin
      unique case (cfg_index)
        stsel_pkg::CFG_FOLLOW_MODE:  follow_mode_nxt  = cfg_wdata[1:0];
        stsel_pkg::CFG_CLASS_FILTER: class_filter_nxt = cfg_wdata[7:0];
        stsel_pkg::CFG_POLICY:       policy_nxt       = cfg_wdata[1:0];
        stsel_pkg::CFG_TIMEOUT:      timeout_nxt      = cfg_wdata[stsel_pkg::TIMEOUT_W-1:0];
        stsel_pkg::CFG_REQ_ID:       req_id_nxt       = cfg_wdata[31:0];
        default:                     cfg_hit          = 1'b0;
      endcase
      if (cfg_hit) begin
        lock_nxt = (follow_mode_nxt == stsel_pkg::FOLLOW_ID) ? req_id_nxt : '0;
      end
    end else if (fire) begin
      if (mid_data.is_tick) begin
        tst_nxt = tst_inc;
        tsf_nxt = tsf_inc;
        if (CW'(tsf_inc) > CW'(timeout_r)) begin
          res_vld             = 1'b1;
          res_data.from_timer = 1'b1;
        end
      end else begin
        if (!hv0_r && match) begin
          held0_nxt = rec;
          hv0_nxt   = 1'b1;
        end
        if (cand && better) begin
          held1_nxt     = rec;
          hv1_nxt       = 1'b1;
          best_dist_nxt = mid_data.sq_dist;
        end
        if (mid_data.last) begin
          res_vld = 1'b1;
          tsf_nxt = '0;
          if ((follow_mode_r == stsel_pkg::FOLLOW_BEST ||
               follow_mode_r == stsel_pkg::FOLLOW_ID) && hv0_nxt) begin
            res_data = found_result(held0_nxt);
            tst_nxt  = '0;
          end else if (follow_mode_r == stsel_pkg::FOLLOW_BEST && hv1_nxt) begin
            res_data = found_result(held1_nxt);
            lock_nxt = held1_nxt.trk_id;
            tst_nxt  = '0;
          end else if (CW'(tst_r) > CW'(timeout_r)) begin
            lock_nxt = '0;
          end
          hv0_nxt       = 1'b0;
          hv1_nxt       = 1'b0;
          best_dist_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      follow_mode_r  <= stsel_pkg::FOLLOW_BEST;
      class_filter_r <= '0;
      policy_r       <= '0;
      timeout_r      <= stsel_pkg::TIMEOUT_W'(20);
      req_id_r       <= '0;
      lock_r         <= '0;
      hv0_r          <= 1'b0;
      hv1_r          <= 1'b0;
      best_dist_r    <= '0;
      tst_r          <= {TCB{1'b1}};
      tsf_r          <= '0;
    end else begin
      follow_mode_r  <= follow_mode_nxt;
      class_filter_r <= class_filter_nxt;
      policy_r       <= policy_nxt;
      timeout_r      <= timeout_nxt;
      req_id_r       <= req_id_nxt;
      lock_r         <= lock_nxt;
      hv0_r          <= hv0_nxt;
      hv1_r          <= hv1_nxt;
      best_dist_r    <= best_dist_nxt;
      tst_r          <= tst_nxt;
      tsf_r          <= tsf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held0_r <= held0_nxt;
    held1_r <= held1_nxt;
  end

endmodule

[hw/rtl/sticky_target_selector_top.sv]
// ----------------------------------------------------------------------------
// sticky_target_selector_top: one-target selector with a sticky lock
// Streams track records frame by frame and timer ticks, and reports one
// target or lost per frame end, and lost on ticks after a frame timeout.
// ----------------------------------------------------------------------------
//
//   channel   ports                               direction  transaction on
//   input     in_push, in_full, in_data           in         in_push & !in_full
//   result    out_empty, out_pop, out_data        out        out_pop & !out_empty
//   config    cfg_we, cfg_index, cfg_wdata        in         cfg_we
//
// One item is accepted per cycle while in_full is low. An item waits in the
// front register (squaring the centre offsets) and then in the internal
// queue; the back stage retires it and writes its result into the output
// queue at the same edge. The back stage retires only while the output
// queue has room and no register write is under way, and in_full rises once
// the internal queue is full and the front register is occupied. Reset is
// synchronous; it empties both queues and restores the register defaults, a
// released lock and a saturated time-since-target counter.
//
module sticky_target_selector_top #(
  parameter int TIME_COUNTER_BITS = stsel_pkg::TIME_COUNTER_BITS_DEF,
  parameter int QUEUE_AW          = stsel_pkg::QUEUE_AW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  stsel_pkg::in_item_t              in_data,
  output logic                             in_full,
  output logic                             out_empty,
  input  logic                             out_pop,
  output stsel_pkg::result_t               out_data,
  input  logic                             cfg_we,
  input  logic [stsel_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stsel_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int MID_W = $bits(stsel_pkg::mid_item_t);
  localparam int RES_W = $bits(stsel_pkg::result_t);

  // Front to queue.
  logic                 mid_push, mid_full, mid_pop, mid_empty;
  stsel_pkg::mid_item_t mid_wdata, mid_rdata;
  logic [MID_W-1:0]     mid_rbits;

  // Back to output queue.
  logic                 res_push, out_full_q;
  stsel_pkg::result_t   res_data;
  logic [RES_W-1:0]     out_bits;

  // The front captures each transaction and computes the squared distance
  // from the image centre, which is the only multiply in the block.
  stsel_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .mid_push (mid_push),
    .mid_data (mid_wdata),
    .mid_full (mid_full)
  );

  // Short queue that decouples the front from the back.
  stsel_fifo #(
    .WIDTH (MID_W),
    .AW    (QUEUE_AW)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (MID_W'(mid_wdata)),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rbits),
    .empty (mid_empty)
  );

  assign mid_rdata = stsel_pkg::mid_item_t'(mid_rbits);

  // The back keeps all selection state; every decision about one entry is
  // made in the cycle it is retired, so the next entry sees updated state.
  stsel_back #(
    .TIME_COUNTER_BITS (TIME_COUNTER_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mid_empty (mid_empty),
    .mid_data  (mid_rdata),
    .mid_pop   (mid_pop),
    .out_full  (out_full_q),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // Output queue; results wait here while the consumer stalls.
  stsel_fifo #(
    .WIDTH (RES_W),
    .AW    (QUEUE_AW)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (RES_W'(res_data)),
    .full  (out_full_q),
    .pop   (out_pop),
    .rdata (out_bits),
    .empty (out_empty)
  );

  assign out_data = stsel_pkg::result_t'(out_bits);

  // A result is only produced while the output queue has room for it.
  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !out_full_q)
    else $error("result pushed into a full output queue");

  // The back never retires from an empty internal queue.
  a_no_mid_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> !mid_empty)
    else $error("entry retired from an empty internal queue");

  // Timer results come from tick entries only, and frame results from records.
  a_timer_origin: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (res_data.from_timer == mid_rdata.is_tick))
    else $error("result origin does not match the retired entry");

  // A lost result carries an all-zero record.
  a_lost_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && !res_data.target_found) |-> (res_data.target_track_id == '0))
    else $error("lost result with a nonzero track id");

endmodule

[test/sticky_target_selector_checker.sv]
// ----------------------------------------------------------------------------
// sticky_target_selector_checker: result prediction and comparison
// Watches the item, result and register channels of the selector, keeps its
// own copy of the lock, held records and tick counters, and compares every
// popped result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module sticky_target_selector_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  logic                             in_full,
  input  stsel_pkg::in_item_t              in_data,
  input  logic                             out_empty,
  input  logic                             out_pop,
  input  stsel_pkg::result_t               out_data,
  input  logic                             cfg_we,
  input  logic [stsel_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stsel_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                               mismatches,
  output int                               outstanding,
  output int                               results_checked,
  output int                               targets_reported
);
  import stsel_pkg::*;

  localparam int CNT_W = TIME_COUNTER_BITS_DEF;

  logic [1:0]           follow_sel;
  logic [7:0]           wanted_class;
  logic [1:0]           policy_sel;
  logic [TIMEOUT_W-1:0] timeout_ticks;
  logic [31:0]          requested_id;

  logic [31:0]          lock_id;
  track_rec_t           held_rec [2];
  logic                 held_ok [2];
  logic [DIST_W-1:0]    best_dist;
  logic [CNT_W-1:0]     since_target;
  logic [CNT_W-1:0]     since_frame;

  result_t              expected_targets [$];

  initial begin
    mismatches       = 0;
    outstanding      = 0;
    results_checked  = 0;
    targets_reported = 0;
  end

  // Squared distance from the image centre in unsigned Q1.30, saturated to 31 bits.
  function automatic logic [DIST_W-1:0] centre_dist(input logic signed [15:0] x,
                                                    input logic signed [15:0] y);
    longint sq;
    sq = longint'(x) * longint'(x) + longint'(y) * longint'(y);
    if (sq >= 64'sd2147483648) return '1;
    return sq[DIST_W-1:0];
  endfunction

  // New predictions join the tail of the queue.
  task automatic expect_result(input result_t r);
    expected_targets.insert(expected_targets.size(), r);
  endtask

  task automatic clear_model();
    follow_sel    = FOLLOW_BEST;
    wanted_class  = '0;
    policy_sel    = '0;
    timeout_ticks = TIMEOUT_W'(20);
    requested_id  = '0;
    lock_id       = '0;
    for (int k = 0; k < 2; k++) begin
      held_rec[k] = '0;
      held_ok[k]  = 1'b0;
    end
    best_dist    = '0;
    since_target = '1;
    since_frame  = '0;
    expected_targets.delete();
  endtask

  task automatic load_register(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
    logic known;
    known = 1'b1;
    case (idx)
      CFG_FOLLOW_MODE:  follow_sel    = val[1:0];
      CFG_CLASS_FILTER: wanted_class  = val[7:0];
      CFG_POLICY:       policy_sel    = val[1:0];
      CFG_TIMEOUT:      timeout_ticks = val[TIMEOUT_W-1:0];
      CFG_REQ_ID:       requested_id  = val;
      default:          known = 1'b0;
    endcase
    // Any write to a real register reloads the lock.
    if (known) lock_id = (follow_sel == FOLLOW_ID) ? requested_id : '0;
  endtask

  task automatic hold_record(input int k, input in_item_t it);
    held_rec[k].trk_id     = it.trk_id;
    held_rec[k].obj_class  = it.obj_class;
    held_rec[k].confidence = it.confidence;
    held_rec[k].center_x   = it.center_x;
    held_rec[k].center_y   = it.center_y;
    held_rec[k].size_ratio = it.size_ratio;
    held_ok[k]             = 1'b1;
  endtask

  task automatic report_held(input int k);
    result_t r;
    r                   = '0;
    r.target_found      = 1'b1;
    r.target_track_id   = held_rec[k].trk_id;
    r.target_class      = held_rec[k].obj_class;
    r.target_confidence = held_rec[k].confidence;
    r.target_center_x   = held_rec[k].center_x;
    r.target_center_y   = held_rec[k].center_y;
    r.target_size       = held_rec[k].size_ratio;
    since_target        = '0;
    expect_result(r);
  endtask

  // A lost frame end also releases a lock that has gone stale.
  task automatic report_lost_frame();
    result_t r;
    r = '0;
    if (since_target > timeout_ticks) lock_id = '0;
    expect_result(r);
  endtask

  task automatic predict_item(input in_item_t it);
    result_t           r;
    logic              cand;
    logic              better;
    logic [DIST_W-1:0] d;
    if (it.mode) begin
      if (since_target != '1) since_target++;
      if (since_frame != '1) since_frame++;
      if (since_frame > timeout_ticks) begin
        r            = '0;
        r.from_timer = 1'b1;
        expect_result(r);
      end
      return;
    end

    if (it.has_track) begin
      cand = (it.obj_class == wanted_class) && (it.trk_id != '0);
      if (!held_ok[0] && ((follow_sel == FOLLOW_BEST && cand && it.trk_id == lock_id) ||
                          (follow_sel == FOLLOW_ID && it.trk_id == lock_id)))
        hold_record(0, it);
      if (cand) begin
        d = centre_dist(it.center_x, it.center_y);
        if (!held_ok[1]) better = 1'b1;
        else begin
          case (policy_sel)
            POL_NEAREST: better = d < best_dist;
            POL_LARGEST: better = it.size_ratio > held_rec[1].size_ratio;
            default:     better = it.confidence > held_rec[1].confidence;
          endcase
        end
        if (better) begin
          hold_record(1, it);
          best_dist = d;
        end
      end
    end

    if (!it.last_of_frame) return;

    since_frame = '0;
    case (follow_sel)
      FOLLOW_BEST: begin
        if (held_ok[0]) report_held(0);
        else if (held_ok[1]) begin
          lock_id = held_rec[1].trk_id;
          report_held(1);
        end else report_lost_frame();
      end
      FOLLOW_ID: begin
        if (held_ok[0]) report_held(0);
        else report_lost_frame();
      end
      default: report_lost_frame();
    endcase
    held_ok[0] = 1'b0;
    held_ok[1] = 1'b0;
    best_dist  = '0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_targets.size() == 0) begin
      $error("result transaction with no prediction waiting: %0h", got);
      mismatches++;
      return;
    end
    want = expected_targets.pop_front();
    results_checked++;
    if (want.target_found) targets_reported++;
    check_field("target_found", want.target_found, got.target_found);
    check_field("from_timer", want.from_timer, got.from_timer);
    check_field("target_track_id", want.target_track_id, got.target_track_id);
    check_field("target_class", want.target_class, got.target_class);
    check_field("target_confidence", want.target_confidence, got.target_confidence);
    check_field("target_center_x", want.target_center_x, got.target_center_x);
    check_field("target_center_y", want.target_center_y, got.target_center_y);
    check_field("target_size", want.target_size, got.target_size);
  endtask

  // Pops are checked before new items are predicted, so a result can never
  // be matched against a prediction made at the same edge.
  always @(posedge clk) begin
    if (!rst_n) clear_model();
    else begin
      if (out_pop && !out_empty) check_result(out_data);
      if (cfg_we) load_register(cfg_index, cfg_wdata);
      if (in_push && !in_full) predict_item(in_data);
    end
    outstanding = expected_targets.size();
  end

endmodule

[test/sticky_target_selector_top_test.sv]
// ----------------------------------------------------------------------------
// sticky_target_selector_top_test: stimulus and verdict for the selector
// Drives frames of track records, timer ticks, stray records and register
// settings into the selector with random gaps and result stalls; a checker
// beside the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module sticky_target_selector_top_test;
  import stsel_pkg::*;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int PHASE_ITEMS  = 48;
  localparam int HOLD_CYCLES  = 300;
  localparam int FILL_ITEMS   = 30;
  // An item passes the front register and the internal queue before its result
  // shows; this leaves ample room for an item that produces no result to retire.
  localparam int DRAIN_CYCLES = 10;

  // Codes that the package leaves unnamed.
  localparam logic [1:0] FOLLOW_CLEARED = 2'd2;
  localparam logic [1:0] FOLLOW_SPARE   = 2'd3;
  localparam logic [1:0] POL_CONFIDENCE = 2'd0;
  localparam logic [1:0] POL_SPARE      = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_push   = 1'b0;
  in_item_t              in_data   = '0;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_pop   = 1'b0;
  result_t               out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int results_checked;
  int targets_reported;

  int cycle_count   = 0;
  int items_sent    = 0;
  int ignored_sent  = 0;
  int settings_used = 0;

  // Sender pacing: calm stretches send back to back, and a burst forces it.
  bit sender_calm  = 1'b0;
  bit no_gaps      = 1'b0;
  // Set by the stimulus to make the receiver stop popping for a long while.
  bit pop_hold_req = 1'b0;

  // Copies of the register values that shape the random records.
  logic [7:0]  cur_class = '0;
  logic [31:0] cur_req   = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sticky_target_selector_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sticky_target_selector_checker selector_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data          (in_data),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_data         (out_data),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .results_checked  (results_checked),
    .targets_reported (targets_reported)
  );

  // Watchdog: a run that stalls or loses results ends here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // The receiver pops results with random stalls and switches now and then
  // into stretches where it pops every cycle. When the stimulus asks for it,
  // it holds off for a long stretch so that both queues of the block fill
  // and in_full rises.
  initial begin : result_drain
    int stall;
    bit calm;
    calm = 1'b0;
    forever begin
      if (pop_hold_req) begin
        out_pop      <= 1'b0;
        pop_hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 19) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty !== 1'b0);
    end
  end

  // Mostly random Q0.16 or Q1.15 values, with the corners drawn often so
  // that ties, saturated distances and sign extremes come up.
  function automatic logic [15:0] pick_q16();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Ids come mostly from a small pool so that locks are found again in
  // later frames; id zero, the requested id and the extremes show up too.
  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return cur_req;
      2:       return '1;
      3:       return $urandom;
      default: return 32'($urandom_range(1, 5));
    endcase
  endfunction

  function automatic logic [7:0] pick_class();
    return ($urandom_range(0, 4) == 0) ? 8'($urandom) : cur_class;
  endfunction

  function automatic in_item_t shaped_rec(input logic [31:0] id, input logic [7:0] cls,
                                         input logic last, input logic [15:0] conf,
                                         input logic [15:0] cx, input logic [15:0] cy,
                                         input logic [15:0] size);
    in_item_t it;
    it               = '0;
    it.has_track     = 1'b1;
    it.last_of_frame = last;
    it.trk_id        = id;
    it.obj_class     = cls;
    it.confidence    = conf;
    it.center_x      = cx;
    it.center_y      = cy;
    it.size_ratio    = size;
    return it;
  endfunction

  function automatic in_item_t track_rec(input logic [31:0] id, input logic [7:0] cls,
                                        input logic last);
    return shaped_rec(id, cls, last, pick_q16(), pick_q16(), pick_q16(), pick_q16());
  endfunction

  // A tick ignores every other field, so they all carry random bits.
  function automatic in_item_t tick_item();
    in_item_t it;
    it           = track_rec($urandom, 8'($urandom), 1'($urandom));
    it.mode      = 1'b1;
    it.has_track = 1'($urandom);
    return it;
  endfunction

  // An invalid record flagged last closes the frame without a track.
  function automatic in_item_t close_item();
    in_item_t it;
    it           = track_rec($urandom, 8'($urandom), 1'b1);
    it.has_track = 1'b0;
    return it;
  endfunction

  // An invalid record that is not last is dropped by the block.
  function automatic in_item_t stray_item();
    in_item_t it;
    it           = track_rec($urandom, 8'($urandom), 1'b0);
    it.has_track = 1'b0;
    return it;
  endfunction

  // One input transaction. The gap before it is drawn per item; in_push is
  // left high after acceptance so that a following item with no gap keeps
  // the valid asserted without a second assignment in the same step.
  task automatic send_item(input in_item_t it);
    int gap;
    if ($urandom_range(0, 24) == 0) sender_calm = !sender_calm;
    gap = (sender_calm || no_gaps) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full !== 1'b0);
    if (it.mode || it.has_track || it.last_of_frame) items_sent++;
    else ignored_sent++;
  endtask

  // Stop sending and wait until every predicted result has been popped,
  // then give a trailing item without a result time to retire. The counter
  // is read at the falling edge, after the checker has updated it.
  task automatic settle();
    in_push <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Unused upper bits of the write data are random, so every data bit
  // toggles while the block must ignore the bits above a register's width.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    logic [31:0] keep;
    case (idx) inside
      CFG_FOLLOW_MODE, CFG_POLICY: keep = 32'h0000_0003;
      CFG_CLASS_FILTER:            keep = 32'h0000_00FF;
      CFG_TIMEOUT:                 keep = 32'h0000_FFFF;
      default:                     keep = '1;
    endcase
    if (idx == CFG_CLASS_FILTER) cur_class = val[7:0];
    if (idx == CFG_REQ_ID) cur_req = val;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= (val & keep) | ($urandom & ~keep);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Registers are only written once the block has gone idle. The requested
  // id goes last, so its write decides the lock; sometimes the follow mode
  // is written again to reload the lock, and sometimes an index with no
  // register behind it is hit, which must change nothing.
  task automatic apply_setting(input logic [1:0] follow, input logic [7:0] cls,
                               input logic [1:0] pol, input logic [15:0] tmo,
                               input logic [31:0] req);
    settle();
    write_reg(CFG_CLASS_FILTER, 32'(cls));
    write_reg(CFG_POLICY, 32'(pol));
    write_reg(CFG_TIMEOUT, 32'(tmo));
    write_reg(CFG_FOLLOW_MODE, 32'(follow));
    write_reg(CFG_REQ_ID, req);
    if ($urandom_range(0, 2) == 0) write_reg(CFG_FOLLOW_MODE, 32'(follow));
    if ($urandom_range(0, 1) == 0)
      write_reg(CFG_IDX_W'($urandom_range(CFG_REQ_ID + 1, (1 << CFG_IDX_W) - 1)), $urandom);
    settings_used++;
  endtask

  // A frame of zero to four records. The last record carries the frame end
  // flag, or a separate invalid record closes the frame; empty frames are
  // closed that way too. Stray records may be mixed in.
  task automatic send_frame();
    int n;
    bit closer;
    n      = $urandom_range(0, 4);
    closer = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(stray_item());
      send_item(track_rec(pick_id(), pick_class(), !closer && i == n - 1));
    end
    if (n == 0 || closer) send_item(close_item());
  endtask

  // Mostly well-formed frames, with bursts of ticks that age the lock and
  // the frame timer, and some stray records.
  task automatic random_phase(input int quota);
    int start;
    int roll;
    start = items_sent;
    while (items_sent - start < quota) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) send_frame();
      else if (roll < 88) repeat ($urandom_range(1, 4)) send_item(tick_item());
      else send_item(stray_item());
    end
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, first with the register defaults: best of class zero,
    // ranked by confidence, timeout of twenty ticks.
    send_item(close_item());   // Empty frame right after reset reports lost.
    send_item(stray_item());   // Dropped without a result.
    send_item(tick_item());    // Frame timer still within the timeout.
    // Id zero is never a candidate, a wrong class is skipped, and the tie
    // between ids 7 and 9 goes to the earlier one, which becomes the lock.
    send_item(shaped_rec(32'd0, 8'd0, 1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    send_item(shaped_rec(32'd7, 8'd0, 1'b0, 16'h8000, 16'h7FFF, 16'h8000, 16'h1234));
    send_item(shaped_rec(32'd9, 8'd0, 1'b0, 16'h8000, 16'h0000, 16'h0000, 16'hFFFF));
    send_item(shaped_rec(32'd5, 8'd3, 1'b1, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001));
    // The lock sticks even when a better track is present.
    send_item(shaped_rec(32'd9, 8'd0, 1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
    send_item(shaped_rec(32'd7, 8'd0, 1'b1, 16'h0000, 16'h8000, 16'h8000, 16'h0000));
    // Without the locked track the best one is locked, with id, confidence, centre and size at maximum.
    send_item(shaped_rec('1, 8'd0, 1'b1, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));

    // A timeout of one tick: ticks report lost once the frame timer passes
    // it, and a lost frame after that releases the stale lock on id 7.
    apply_setting(FOLLOW_BEST, 8'd0, POL_CONFIDENCE, 16'd1, 32'd0);
    send_item(shaped_rec(32'd7, 8'd0, 1'b1, 16'h0100, 16'h0010, 16'h0010, 16'h0100));
    repeat (3) send_item(tick_item());
    send_item(close_item());
    send_item(shaped_rec(32'd9, 8'd0, 1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0001));
    send_item(shaped_rec(32'd7, 8'd0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0001));

    // Following a fixed id of zero: a record with id zero is a target.
    apply_setting(FOLLOW_ID, 8'd5, POL_NEAREST, 16'd20, 32'd0);
    send_item(shaped_rec(32'd0, 8'd9, 1'b1, 16'h0200, 16'hFFF0, 16'h0010, 16'h0300));
    send_item(shaped_rec(32'd6, 8'd5, 1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));

    // Random part, one register setting per phase, extremes included.
    apply_setting(FOLLOW_BEST, 8'd0, POL_NEAREST, 16'd0, $urandom);
    random_phase(PHASE_ITEMS);
    apply_setting(FOLLOW_BEST, 8'hFF, POL_LARGEST, 16'd3, '1);
    random_phase(PHASE_ITEMS);
    apply_setting(FOLLOW_ID, 8'($urandom), POL_CONFIDENCE, 16'hFFFF, 32'd0);
    random_phase(PHASE_ITEMS);
    apply_setting(FOLLOW_ID, 8'd5, POL_NEAREST, 16'd2, 32'd3);
    random_phase(PHASE_ITEMS);

    // Fill the block: the receiver holds off while frames with one record
    // each arrive back to back, so both queues fill and in_full rises.
    settle();
    pop_hold_req = 1'b1;
    no_gaps      = 1'b1;
    repeat (FILL_ITEMS) send_item(track_rec(pick_id(), pick_class(), 1'b1));
    no_gaps = 1'b0;

    apply_setting(FOLLOW_CLEARED, 8'($urandom), POL_LARGEST, 16'd1, 32'd2);
    random_phase(PHASE_ITEMS);
    apply_setting(FOLLOW_SPARE, 8'd1, POL_SPARE, 16'd5, 32'd4);
    random_phase(PHASE_ITEMS);
    apply_setting(FOLLOW_BEST, 8'($urandom), POL_SPARE, 16'($urandom_range(0, 8)), $urandom);
    random_phase(PHASE_ITEMS);
    apply_setting(FOLLOW_ID, 8'd2, 2'($urandom), 16'd20, 32'($urandom_range(1, 5)));
    random_phase(PHASE_ITEMS);

    settle();
    $display("Covered %0d frame and tick transactions and %0d stray records over %0d settings.",
             items_sent, ignored_sent, settings_used);
    $display("Compared %0d result transactions, %0d of them carrying a target.",
             results_checked, targets_reported);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sticky_target_selector_top.f]
hw/rtl/stsel_pkg.sv
hw/rtl/stsel_fifo.sv
hw/rtl/stsel_front.sv
hw/rtl/stsel_back.sv
hw/rtl/sticky_target_selector_top.sv
test/sticky_target_selector_checker.sv
test/sticky_target_selector_top_test.sv
